[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. Each form samples on clk and is
// disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define TSWQ_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TSWQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/tswq_pkg.sv]
// ----------------------------------------------------------------------------
// Timed sorted wait queue package
// Widths, codes, reset values and types shared by the queue files.
// ----------------------------------------------------------------------------
`default_nettype none

package tswq_pkg;

	localparam int QUEUE_DEPTH_DEF = 32;
	localparam int HANDLE_W        = 16;
	localparam int TIME_W          = 16;
	localparam int OPC_W           = 2;
	localparam int OCC_W           = 6;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 16;

	localparam logic [TIME_W-1:0] INF_WAIT_RST = 16'hFFFF;
	localparam logic [TIME_W-1:0] MAX_WAIT_RST = 16'hFFFE;

	typedef enum logic [OPC_W-1:0] {
		OP_APPEND = 2'd0,
		OP_INSERT = 2'd1,
		OP_POP    = 2'd2,
		OP_NOP    = 2'd3
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INF_WAIT = 2'd0,
		CFG_MAX_WAIT = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [HANDLE_W-1:0] handle;
		logic [TIME_W-1:0]   tag;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POP,
		ST_RD,
		ST_CMP,
		ST_TAIL
	} state_t;

endpackage

`default_nettype wire

[rtl/tswq_channels.sv]
// ----------------------------------------------------------------------------
// Timed sorted wait queue channels
// Valid/ready channels for configuration writes, requests and responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface tswq_cfg_if import tswq_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

interface tswq_req_if import tswq_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OPC_W-1:0]    opcode;
	logic [HANDLE_W-1:0] task_handle;
	logic [TIME_W-1:0]   wait_time;

	modport source (output valid, opcode, task_handle, wait_time, input ready);
	modport sink   (input valid, opcode, task_handle, wait_time, output ready);
endinterface

interface tswq_rsp_if import tswq_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [HANDLE_W-1:0] popped_handle;
	logic                was_empty;
	logic                overflow;
	logic [OCC_W-1:0]    occupancy;

	modport source (output valid, popped_handle, was_empty, overflow, occupancy, input ready);
	modport sink   (input valid, popped_handle, was_empty, overflow, occupancy, output ready);
endinterface

`default_nettype wire

[rtl/timed_sorted_wait_queue_unit.sv]
// ----------------------------------------------------------------------------
// Timed sorted wait queue unit
// Bounded queue of task handles tagged with wait times: append, sorted
// insert and pop front, one response beat per request beat.
// Usage:
//  - cfg: write beats set the infinite wait tag (index 0) and the wait clamp
//    (index 1). Always ready; write only while the queue is idle.
//  - req: one beat per operation. ready is high only when the sequencer is
//    idle and no response is waiting.
//  - rsp: one beat per request, held in an output register until taken.
// Steps, request beat to response valid:
//  - append, pop on empty, full drops, unused opcode: response loaded from idle
//  - pop: one read of the entry RAM, then the pop state loads the response
//  - sorted insert: every stored entry is read
//    and compared in turn, and entries behind the insertion point are moved
//    up one place through the single RAM read and write port.
// Operations run one at a time; the next request beat can be taken in the
// cycle after the response beat is taken. Reset clears the count, head
// pointer and sequencer and sets the configuration to its reset values. The
// entry RAM is not cleared. A stalled response holds and blocks new requests.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_sorted_wait_queue_unit import tswq_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	tswq_cfg_if.sink   cfg,
	tswq_req_if.sink   req,
	tswq_rsp_if.source rsp
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = AW + 1;
	localparam logic [SW-1:0] DEPTH_S = SW'(QUEUE_DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

	// Map a logical position behind the head to a RAM address (circular).
	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
	                                           input logic [CW-1:0] off);
		logic [SW-1:0] sum;
		sum = SW'(base) + SW'(off);
		if (sum >= DEPTH_S) begin
			sum = sum - DEPTH_S;
		end
		return sum[AW-1:0];
	endfunction

	// Sequencer and queue bookkeeping
	state_t        state_q, state_d;
	logic [AW-1:0] head_q, head_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] idx_q, idx_d;
	logic          found_q, found_d;

	// Item in flight
	logic [HANDLE_W-1:0] hnd_q, hnd_d;
	logic [TIME_W-1:0]   tag_q, tag_d;
	entry_t              carry_q, carry_d;

	// Configuration
	logic [TIME_W-1:0] inf_q;
	logic [TIME_W-1:0] max_q;

	// Entry RAM
	entry_t        ram_q [QUEUE_DEPTH];
	entry_t        rd_q;
	logic          we;
	logic [AW-1:0] waddr;
	entry_t        wdata;
	logic [AW-1:0] raddr;

	// Response register
	logic                rsp_valid_q;
	logic [HANDLE_W-1:0] popped_q, popped_d;
	logic                empty_q, empty_d;
	logic                ovf_q, ovf_d;
	logic [OCC_W-1:0]    occ_q, occ_d;
	logic                rsp_load;

	logic              req_rdy;
	logic              req_fire;
	logic              full;
	logic [TIME_W-1:0] tag_new;

	// Take a request only when idle with the response slot empty.
	assign req_rdy   = (state_q == ST_IDLE) && !rsp_valid_q;
	assign req.ready = req_rdy;
	assign req_fire  = req.valid && req_rdy;
	assign cfg.ready = 1'b1;
	assign full      = (count_q == DEPTH_C);

	// Zero asks for the infinite tag (never clamped); otherwise clamp.
	always_comb begin
		if (req.wait_time == '0) begin
			tag_new = inf_q;
		end else if (req.wait_time > max_q) begin
			tag_new = max_q;
		end else begin
			tag_new = req.wait_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inf_q <= INF_WAIT_RST;
			max_q <= MAX_WAIT_RST;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				CFG_INF_WAIT: inf_q <= cfg.data;
				CFG_MAX_WAIT: max_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
			idx_q   <= idx_d;
			found_q <= found_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		hnd_q   <= hnd_d;
		tag_q   <= tag_d;
		carry_q <= carry_d;
		if (rsp_load) begin
			popped_q <= popped_d;
			empty_q  <= empty_d;
			ovf_q    <= ovf_d;
			occ_q    <= occ_d;
		end
	end

	// Single-port-write, single-port-read RAM with registered read data.
	always_ff @(posedge clk) begin
		if (we) begin
			ram_q[waddr] <= wdata;
		end
		rd_q <= ram_q[raddr];
	end

	always_comb begin
		state_d  = state_q;
		head_d   = head_q;
		count_d  = count_q;
		idx_d    = idx_q;
		found_d  = found_q;
		hnd_d    = hnd_q;
		tag_d    = tag_q;
		carry_d  = carry_q;
		we       = 1'b0;
		waddr    = wrap_add(head_q, count_q);
		wdata    = '{handle: hnd_q, tag: tag_q};
		raddr    = wrap_add(head_q, idx_q);
		rsp_load = 1'b0;
		popped_d = '0;
		empty_d  = 1'b0;
		ovf_d    = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				// Read the front entry speculatively: pop and insert both need it.
				raddr = head_q;
				if (req_fire) begin
					hnd_d   = req.task_handle;
					tag_d   = tag_new;
					idx_d   = '0;
					found_d = 1'b0;
					unique case (opcode_t'(req.opcode))
						OP_APPEND: begin
							rsp_load = 1'b1;
							if (full) begin
								ovf_d = 1'b1;
							end else begin
								we      = 1'b1;
								wdata   = '{handle: req.task_handle, tag: '0};
								count_d = count_q + CW'(1);
							end
						end
						OP_INSERT: begin
							if (full) begin
								ovf_d    = 1'b1;
								rsp_load = 1'b1;
							end else if (count_q == '0) begin
								we       = 1'b1;
								wdata    = '{handle: req.task_handle, tag: tag_new};
								count_d  = CW'(1);
								rsp_load = 1'b1;
							end else begin
								state_d = ST_CMP;
							end
						end
						OP_POP: begin
							if (count_q == '0) begin
								empty_d  = 1'b1;
								rsp_load = 1'b1;
							end else begin
								state_d = ST_POP;
							end
						end
						OP_NOP: begin
							rsp_load = 1'b1;
						end
						default: ;
					endcase
				end
			end
			ST_POP: begin
				// Front entry is in rd_q; advance the head.
				popped_d = rd_q.handle;
				head_d   = wrap_add(head_q, CW'(1));
				count_d  = count_q - CW'(1);
				rsp_load = 1'b1;
				state_d  = ST_IDLE;
			end
			ST_RD: begin
				state_d = ST_CMP;
			end
			ST_CMP: begin
				// Before the insertion point: compare. From it on: ripple each
				// entry up one place, carrying the displaced one forward.
				waddr = wrap_add(head_q, idx_q);
				if (found_q) begin
					we      = 1'b1;
					wdata   = carry_q;
					carry_d = rd_q;
				end else if (tag_q <= rd_q.tag) begin
					we      = 1'b1;
					wdata   = '{handle: hnd_q, tag: tag_q};
					carry_d = rd_q;
					found_d = 1'b1;
				end
				idx_d = idx_q + CW'(1);
				if (idx_d == count_q) begin
					state_d = ST_TAIL;
				end else begin
					state_d = ST_RD;
				end
			end
			ST_TAIL: begin
				// Write the last displaced entry, or the new one if none was larger or equal.
				we       = 1'b1;
				wdata    = found_q ? carry_q : entry_t'{handle: hnd_q, tag: tag_q};
				count_d  = count_q + CW'(1);
				rsp_load = 1'b1;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		occ_d = OCC_W'(count_d);
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.popped_handle = popped_q;
	assign rsp.was_empty     = empty_q;
	assign rsp.overflow      = ovf_q;
	assign rsp.occupancy     = occ_q;

endmodule

`default_nettype wire

[rtl/tswq_checker.sv]
// ----------------------------------------------------------------------------
// Timed sorted wait queue checker
// Port-level assertions on the queue unit, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tswq_checker import tswq_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                req_valid,
	input wire logic                req_ready,
	input wire logic                rsp_valid,
	input wire logic                rsp_ready,
	input wire logic [HANDLE_W-1:0] rsp_popped_handle,
	input wire logic                rsp_was_empty,
	input wire logic                rsp_overflow,
	input wire logic [OCC_W-1:0]    rsp_occupancy
);

	// One operation at a time: no new request while a response waits.
	`TSWQ_ASSERT_IMPLY(a_ready_no_rsp, req_ready, !rsp_valid, "request ready with response pending")

	// An accepted beat keeps the request side closed on the next cycle.
	`TSWQ_ASSERT_NEXT(a_accept_busy, req_valid && req_ready, !req_ready, "ready right after accept")

	// Failed pops and dropped appends and inserts return no handle.
	`TSWQ_ASSERT_IMPLY(a_flag_no_handle, rsp_valid && (rsp_was_empty || rsp_overflow), rsp_popped_handle == '0, "handle with flag set")

	// Occupancy never exceeds the depth (checked only for depths up to 63).
	`TSWQ_ASSERT_IMPLY(a_occ_bound, rsp_valid, (QUEUE_DEPTH > 63) || (int'(rsp_occupancy) <= QUEUE_DEPTH), "occupancy above depth")

	// Stalled response holds.
	`TSWQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_popped_handle) && $stable(rsp_occupancy), "stalled response changed")

endmodule

bind timed_sorted_wait_queue_unit tswq_checker #(
	.QUEUE_DEPTH(QUEUE_DEPTH)
) u_tswq_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_popped_handle(rsp.popped_handle),
	.rsp_was_empty    (rsp.was_empty),
	.rsp_overflow     (rsp.overflow),
	.rsp_occupancy    (rsp.occupancy)
);

`default_nettype wire

[verif/timed_sorted_wait_queue_unit_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Timed sorted wait queue unit test
// Drives append, sorted insert, pop and unused-opcode beats into the queue
// under several wait-tag settings. A shadow queue predicts every response
// beat, and each one is checked field by field against it. Both channels
// idle at random, with one stretch where neither side idles.
// ----------------------------------------------------------------------------

module timed_sorted_wait_queue_unit_test;
	import tswq_pkg::*;

	localparam int DEPTH        = QUEUE_DEPTH_DEF;
	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int REPORT_MAX   = 10;

	typedef struct packed {
		logic [HANDLE_W-1:0] popped_handle;
		logic                was_empty;
		logic                overflow;
		logic [OCC_W-1:0]    occupancy;
	} queue_result_t;

	// Shadow copy of the queue: predicts one response per request beat and
	// holds the predictions until the matching response beats arrive.
	class wait_queue_shadow;
		logic [HANDLE_W-1:0] handles[DEPTH];
		logic [TIME_W-1:0]   tags[DEPTH];
		int unsigned         count;
		logic [TIME_W-1:0]   inf_tag;
		logic [TIME_W-1:0]   max_tag;
		queue_result_t       expected_q[$];
		int unsigned         mismatches;
		int unsigned         checked;
		int unsigned         n_append, n_insert, n_pop, n_empty, n_drop, n_nop;

		function void clear();
			count   = 0;
			inf_tag = INF_WAIT_RST;
			max_tag = MAX_WAIT_RST;
			expected_q.delete();
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_INF_WAIT: inf_tag = val;
				CFG_MAX_WAIT: max_tag = val;
				default: ;
			endcase
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		function void note_request(opcode_t op, logic [HANDLE_W-1:0] h,
				logic [TIME_W-1:0] wt);
			queue_result_t     r;
			logic [TIME_W-1:0] tag;
			int unsigned       pos;
			int unsigned       i;
			r = '0;
			case (op)
				OP_APPEND, OP_INSERT: begin
					if (count >= DEPTH) begin
						r.overflow = 1'b1;
						n_drop++;
					end else begin
						if (op == OP_APPEND) begin
							tag = '0;
							pos = count;
							n_append++;
						end else begin
							if (wt == 0)
								tag = inf_tag;
							else if (wt > max_tag)
								tag = max_tag;
							else
								tag = wt;
							pos = 0;
							while (pos < count && tag > tags[pos])
								pos++;
							n_insert++;
						end
						for (i = count; i > pos; i--) begin
							handles[i] = handles[i-1];
							tags[i]    = tags[i-1];
						end
						handles[pos] = h;
						tags[pos]    = tag;
						count++;
					end
				end
				OP_POP: begin
					n_pop++;
					if (count == 0) begin
						r.was_empty = 1'b1;
						n_empty++;
					end else begin
						r.popped_handle = handles[0];
						for (i = 1; i < count; i++) begin
							handles[i-1] = handles[i];
							tags[i-1]    = tags[i];
						end
						count--;
					end
				end
				default: n_nop++;
			endcase
			r.occupancy = count[OCC_W-1:0];
			expected_q.push_back(r);
		endfunction

		function void check_response(queue_result_t got);
			queue_result_t exp;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("response beat with no request pending: handle %h empty %b ovf %b occ %0d",
						got.popped_handle, got.was_empty, got.overflow, got.occupancy);
				return;
			end
			exp = expected_q.pop_front();
			checked++;
			if (got.popped_handle !== exp.popped_handle || got.was_empty !== exp.was_empty ||
					got.overflow !== exp.overflow || got.occupancy !== exp.occupancy) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("response %0d: expected handle %h empty %b ovf %b occ %0d, got handle %h empty %b ovf %b occ %0d",
						checked, exp.popped_handle, exp.was_empty, exp.overflow, exp.occupancy,
						got.popped_handle, got.was_empty, got.overflow, got.occupancy);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	tswq_cfg_if cfg_ch ();
	tswq_req_if req_ch ();
	tswq_rsp_if rsp_ch ();

	wait_queue_shadow shadow;

	// When set, neither side idles: back-to-back beats on both channels.
	bit          no_gaps = 1'b0;
	int unsigned cycles  = 0;
	int unsigned settings_used = 0;

	timed_sorted_wait_queue_unit #(
		.QUEUE_DEPTH(DEPTH)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #5 clk = ~clk;

	// Watchdog: end the run if it goes far past any correct run length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d responses outstanding",
				cycles, shadow.pending());
			$display("Mismatches found");
			$finish;
		end
	end

	// Roughly a third of the cycles idle on each side, unless gaps are off.
	function automatic bit idle_now();
		return !no_gaps && ($urandom_range(0, 99) < 34);
	endfunction

	// Response side: sample the beat on the falling edge (values there are
	// the ones the next rising edge sees), then check it at that edge and
	// pick the next ready level.
	initial begin : rsp_sink
		queue_result_t got;
		bit            take;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			take = arst_n && rsp_ch.valid && rsp_ch.ready;
			got.popped_handle = rsp_ch.popped_handle;
			got.was_empty     = rsp_ch.was_empty;
			got.overflow      = rsp_ch.overflow;
			got.occupancy     = rsp_ch.occupancy;
			@(posedge clk);
			if (take)
				shadow.check_response(got);
			rsp_ch.ready <= !idle_now();
		end
	end

	// Send one request beat. Valid is left high on return so that the next
	// beat can follow without a gap; an idle cycle lowers it first.
	task automatic send_request(opcode_t op, logic [HANDLE_W-1:0] h,
			logic [TIME_W-1:0] wt);
		bit hs;
		while (idle_now()) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.opcode      <= op;
		req_ch.task_handle <= h;
		req_ch.wait_time   <= wt;
		do begin
			@(negedge clk);
			hs = req_ch.ready;
			@(posedge clk);
		end while (!hs);
		shadow.note_request(op, h, wt);
	endtask

	// Hold off new requests until every predicted response has been taken,
	// then give the sequencer a few cycles to settle.
	task automatic drain_queue_ops();
		req_ch.valid <= 1'b0;
		while (shadow.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write one register; valid stays high so a second write can follow.
	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		bit hs;
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do begin
			@(negedge clk);
			hs = cfg_ch.ready;
			@(posedge clk);
		end while (!hs);
		shadow.write_reg(idx, val);
	endtask

	// Drain, then load both wait-tag registers.
	task automatic set_wait_tags(logic [TIME_W-1:0] inf_val, logic [TIME_W-1:0] max_val);
		drain_queue_ops();
		write_reg(CFG_INF_WAIT, inf_val);
		write_reg(CFG_MAX_WAIT, max_val);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	// Wait times lean toward the interesting spots: zero, the top value,
	// values right at the clamp and small values that collide into ties.
	function automatic logic [TIME_W-1:0] pick_wait();
		logic [TIME_W-1:0] wt;
		case ($urandom_range(0, 7))
			0: wt = '0;
			1: wt = '1;
			2: wt = shadow.max_tag + TIME_W'($urandom_range(0, 2));
			3, 4: wt = TIME_W'($urandom_range(1, 8));
			default: wt = TIME_W'($urandom);
		endcase
		return wt;
	endfunction

	// One block of random beats; pop_pct steers the fill level, so low
	// values run the queue into its full state and high values empty it.
	task automatic run_block(int unsigned n, int unsigned pop_pct);
		opcode_t op;
		int unsigned k;
		for (k = 0; k < n; k++) begin
			if ($urandom_range(0, 99) < pop_pct)
				op = OP_POP;
			else if ($urandom_range(0, 19) == 0)
				op = OP_NOP;
			else if ($urandom_range(0, 9) < 3)
				op = OP_APPEND;
			else
				op = OP_INSERT;
			send_request(op, HANDLE_W'($urandom), pick_wait());
		end
	endtask

	// A phase: ten blocks of 40 beats with a random fill bias per block.
	task automatic run_phase(bit mid_drain);
		int unsigned b;
		int unsigned bias;
		for (b = 0; b < 10; b++) begin
			case ($urandom_range(0, 2))
				0: bias = 5;
				1: bias = 45;
				default: bias = 80;
			endcase
			run_block(40, bias);
			if (mid_drain && b == 4)
				drain_queue_ops();
		end
	endtask

	initial begin : stimulus
		int unsigned k;
		shadow = new();
		shadow.clear();
		arst_n             <= 1'b0;
		cfg_ch.valid       <= 1'b0;
		cfg_ch.index       <= CFG_INF_WAIT;
		cfg_ch.data        <= '0;
		req_ch.valid       <= 1'b0;
		req_ch.opcode      <= OP_NOP;
		req_ch.task_handle <= '0;
		req_ch.wait_time   <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset tag values: empty pop, unused opcode,
		// handle extremes, zero wait mapped to the infinite tag, clamp of the
		// top value, equal tags going ahead of older ones, then a full drain.
		send_request(OP_POP,    16'h1234, 16'h0000);
		send_request(OP_NOP,    16'hFFFF, 16'hFFFF);
		send_request(OP_APPEND, 16'hFFFF, 16'hFFFF);
		send_request(OP_APPEND, 16'h0000, 16'h0000);
		send_request(OP_INSERT, 16'h1111, 16'h0000);
		send_request(OP_INSERT, 16'h2222, 16'hFFFF);
		send_request(OP_INSERT, 16'h3333, 16'h0001);
		send_request(OP_INSERT, 16'h4444, 16'h0001);
		send_request(OP_INSERT, 16'h5555, 16'h8000);
		send_request(OP_NOP,    16'h0000, 16'h0000);
		for (k = 0; k < 8; k++)
			send_request(OP_POP, 16'h0000, 16'h0000);

		// Infinite tag above the clamp: a zero wait must not be clamped.
		set_wait_tags(16'hFFFF, 16'd100);
		send_request(OP_INSERT, 16'h6666, 16'h0000);
		send_request(OP_INSERT, 16'h7777, 16'd500);
		send_request(OP_INSERT, 16'h8888, 16'd100);
		for (k = 0; k < 4; k++)
			send_request(OP_POP, 16'h0000, 16'h0000);

		// Random phases, one per tag setting; the third runs without gaps.
		set_wait_tags(INF_WAIT_RST, MAX_WAIT_RST);
		run_phase(1'b1);
		set_wait_tags(16'hFFFF, 16'd100);
		run_phase(1'b0);
		set_wait_tags(16'h0000, 16'h0000);
		no_gaps = 1'b1;
		run_phase(1'b0);
		no_gaps = 1'b0;
		set_wait_tags(16'd40, 16'hFFFF);
		run_phase(1'b1);
		set_wait_tags(TIME_W'($urandom), TIME_W'($urandom));
		run_phase(1'b0);

		// Let the last responses come back, then allow a worst-case insert
		// worth of cycles for any stray beat.
		drain_queue_ops();
		repeat (2 * DEPTH + 8) @(posedge clk);

		$display("covered %0d appends, %0d sorted inserts, %0d pops (%0d on empty), %0d full drops, %0d unused opcodes",
			shadow.n_append, shadow.n_insert, shadow.n_pop, shadow.n_empty,
			shadow.n_drop, shadow.n_nop);
		$display("%0d tag settings, %0d responses checked, %0d mismatching",
			settings_used, shadow.checked, shadow.mismatches);
		if (shadow.mismatches == 0 && shadow.pending() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
